// ===== src/calendar_date_add_days_assert.svh =====
// Assertion macros used by the date adder datapath
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// same-cycle implication
`define CDAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/cdad_pkg.sv =====
// Types, constants and calendar functions of the date adder
`timescale 1ns / 1ps
package cdad_pkg;

   localparam int YEAR_BITS_DEFAULT  = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 16;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int MOD_W    = 9;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

   localparam logic [MOD_W-1:0] CYCLE_YEARS = 9'd400;
   localparam logic [17:0]      CYCLE_DAYS  = 18'd146097;

   typedef struct packed {
      logic load;
      logic reduce;
      logic check;
      logic step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic reduce_last;
      logic date_bad;
      logic run_end;
      logic out_busy;
   } sts_type;

   // leap test on the year taken modulo 400
   function automatic logic is_leap(input logic [MOD_W-1:0] q);
      return (q == '0) ||
             ((q[1:0] == 2'd0) && (q != 9'd100) && (q != 9'd200) && (q != 9'd300));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== src/cdad_ctrl.sv =====
// Sequencer of the date adder: load, year reduction, check, stepping, publish
`timescale 1ns / 1ps
module cdad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdad_pkg::sts_type sts,
   output cdad_pkg::cmd_type cmd
);
   import cdad_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_RUN    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (sts.reduce_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.date_bad ? ST_DONE : ST_RUN;
         end
         ST_RUN: begin
            if (sts.run_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/cdad_dpath.sv =====
// Datapath of the date adder: date registers, year reduction, stepping, result register
`timescale 1ns / 1ps
`include "calendar_date_add_days_assert.svh"
module cdad_dpath #(
   parameter int YEAR_BITS  = cdad_pkg::YEAR_BITS_DEFAULT,
   parameter int COUNT_BITS = cdad_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cdad_pkg::cmd_type                cmd,
   output cdad_pkg::sts_type                sts,
   input  logic [cdad_pkg::DAY_W-1:0]       req_in_day,
   input  logic [cdad_pkg::MONTH_W-1:0]     req_in_month,
   input  logic [cdad_pkg::YEAR_W-1:0]      req_in_year,
   input  logic [cdad_pkg::COUNT_W-1:0]     req_days_to_add,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cdad_pkg::DAY_W-1:0]       rsp_out_day,
   output logic [cdad_pkg::MONTH_W-1:0]     rsp_out_month,
   output logic [cdad_pkg::YEAR_W-1:0]      rsp_out_year,
   output logic [cdad_pkg::STATUS_W-1:0]    rsp_status
);
   import cdad_pkg::*;

   localparam int IDX_W = $clog2(YEAR_BITS);
   localparam int NX_W  = (COUNT_BITS > 18) ? COUNT_BITS : 18;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

   logic [DAY_W-1:0]      d_ff, d_in;
   logic [MONTH_W-1:0]    m_ff, m_in;
   logic [YEAR_BITS:0]    y_ff, y_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [MOD_W-1:0]      q_ff, q_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]      out_day_ff;
   logic [MONTH_W-1:0]    out_month_ff;
   logic [YEAR_W-1:0]     out_year_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   logic [YEAR_BITS-1:0]  y_low;
   logic                  leap;
   logic [DAY_W-1:0]      dim;
   logic [DAY_W-1:0]      left;
   logic [NX_W-1:0]       nx;
   logic [8:0]            year_len;
   logic                  jan1;
   logic                  ovf;
   logic                  date_bad;
   logic [MOD_W:0]        rem2;
   logic [MOD_W-1:0]      q_red;
   logic [MOD_W-1:0]      q_inc;

   assign y_low    = y_ff[YEAR_BITS-1:0];
   assign leap     = is_leap(q_ff);
   assign dim      = month_days(m_ff, leap);
   assign left     = dim - d_ff;
   assign nx       = NX_W'(n_ff);
   assign year_len = leap ? 9'd366 : 9'd365;
   assign jan1     = (d_ff == DAY_FIRST) && (m_ff == MONTH_JAN);
   assign ovf      = y_ff[YEAR_BITS];
   assign date_bad = (m_ff < MONTH_JAN) || (m_ff > MONTH_DEC) || (d_ff == '0) || (d_ff > dim);
   assign rem2     = {q_ff, y_low[idx_ff]};
   assign q_red    = (rem2 >= 10'd400) ? MOD_W'(rem2 - 10'd400) : MOD_W'(rem2);
   assign q_inc    = (q_ff == CYCLE_YEARS - 9'd1) ? '0 : q_ff + 9'd1;

   assign sts.reduce_last = (idx_ff == '0);
   assign sts.date_bad    = date_bad;
   assign sts.run_end     = ovf || (n_ff == '0);
   assign sts.out_busy    = rsp_valid_ff && !rsp_ready;

   always_comb begin
      d_in   = d_ff;
      m_in   = m_ff;
      y_in   = y_ff;
      n_in   = n_ff;
      q_in   = q_ff;
      idx_in = idx_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         d_in   = req_in_day;
         m_in   = req_in_month;
         y_in   = (YEAR_BITS+1)'(YEAR_BITS'(req_in_year));
         n_in   = COUNT_BITS'(req_days_to_add);
         q_in   = '0;
         idx_in = IDX_W'(YEAR_BITS - 1);
         bad_in = 1'b0;
      end else if (cmd.reduce) begin
         q_in   = q_red;
         idx_in = idx_ff - IDX_W'(1);
      end else if (cmd.check) begin
         bad_in = date_bad;
      end else if (cmd.step) begin
         priority if (jan1 && (nx >= NX_W'(CYCLE_DAYS))) begin
            n_in = COUNT_BITS'(nx - NX_W'(CYCLE_DAYS));
            y_in = y_ff + (YEAR_BITS+1)'(CYCLE_YEARS);
         end else if (jan1 && (nx >= NX_W'(year_len))) begin
            n_in = COUNT_BITS'(nx - NX_W'(year_len));
            y_in = y_ff + (YEAR_BITS+1)'(1);
            q_in = q_inc;
         end else if (nx <= NX_W'(left)) begin
            d_in = d_ff + DAY_W'(n_ff);
            n_in = '0;
         end else begin
            n_in = COUNT_BITS'(nx - NX_W'(left) - NX_W'(1));
            d_in = DAY_FIRST;
            if (m_ff == MONTH_DEC) begin
               m_in = MONTH_JAN;
               y_in = y_ff + (YEAR_BITS+1)'(1);
               q_in = q_inc;
            end else begin
               m_in = m_ff + MONTH_W'(1);
            end
         end
      end
   end

   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         q_ff         <= '0;
         bad_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      m_ff   <= m_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      idx_ff <= idx_in;
      if (cmd.publish) begin
         if (bad_ff) begin
            out_day_ff    <= d_ff;
            out_month_ff  <= m_ff;
            out_year_ff   <= YEAR_W'(y_low);
            out_status_ff <= STATUS_INVALID;
         end else if (ovf) begin
            out_day_ff    <= DAY_LAST;
            out_month_ff  <= MONTH_DEC;
            out_year_ff   <= YEAR_W'(YEAR_MAX);
            out_status_ff <= STATUS_OVERFLOW;
         end else begin
            out_day_ff    <= d_ff;
            out_month_ff  <= m_ff;
            out_year_ff   <= YEAR_W'(y_low);
            out_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_day   = out_day_ff;
   assign rsp_out_month = out_month_ff;
   assign rsp_out_year  = out_year_ff;
   assign rsp_status    = out_status_ff;

   `CDAD_ASSERT_IMPL(a_mod_range, clock, reset, 1'b1, q_ff < CYCLE_YEARS)
   `CDAD_ASSERT_IMPL(a_step_month, clock, reset, cmd.step, (m_ff >= MONTH_JAN) && (m_ff <= MONTH_DEC))
   `CDAD_ASSERT_IMPL(a_step_day, clock, reset, cmd.step, (d_ff != '0) && (d_ff <= dim))
   `CDAD_ASSERT_IMPL(a_step_live, clock, reset, cmd.step, !ovf && (n_ff != '0) && !bad_ff)
   `CDAD_ASSERT_NEXT(a_publish, clock, reset, cmd.publish, rsp_valid_ff)

endmodule

// ===== src/calendar_date_add_days.sv =====
// From accept to rsp_valid the sequencer runs load, year reduction, check, stepping and
// publish; an invalid date skips stepping. A new transaction is taken only after publish.
// Year reduction builds the year modulo 400, one bit per cycle. Stepping goes by whole months
// up to January 1st, then by 400-year cycles, then by whole years, then by remaining months,
// and ends with the days left in the last month. A new transaction is taken while the
// previous result waits in the output register. Synchronous reset clears sequencer and valid.
`timescale 1ns / 1ps
module calendar_date_add_days #(
   parameter int YEAR_BITS  = cdad_pkg::YEAR_BITS_DEFAULT,
   parameter int COUNT_BITS = cdad_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cdad_pkg::DAY_W-1:0]    req_in_day,
   input  logic [cdad_pkg::MONTH_W-1:0]  req_in_month,
   input  logic [cdad_pkg::YEAR_W-1:0]   req_in_year,
   input  logic [cdad_pkg::COUNT_W-1:0]  req_days_to_add,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cdad_pkg::DAY_W-1:0]    rsp_out_day,
   output logic [cdad_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic [cdad_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic [cdad_pkg::STATUS_W-1:0] rsp_status
);
   import cdad_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdad_dpath #(
      .YEAR_BITS  (YEAR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_in_day      (req_in_day),
      .req_in_month    (req_in_month),
      .req_in_year     (req_in_year),
      .req_days_to_add (req_days_to_add),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Gregorian date adder: directed and random date transactions
`timescale 1ns / 1ps
module tb;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 500;
   localparam int unsigned HOLD_CYCLES = 3000;
   localparam int unsigned RANDOM_ITEMS = 250;

   class date_scoreboard;
      typedef struct packed {
         logic [cdad_pkg::DAY_W-1:0]    day;
         logic [cdad_pkg::MONTH_W-1:0]  month;
         logic [cdad_pkg::YEAR_W-1:0]   year;
         logic [cdad_pkg::STATUS_W-1:0] status;
      } date_rec_type;

      localparam int unsigned YEAR_TOP = (1 << cdad_pkg::YEAR_BITS_DEFAULT) - 1;

      date_rec_type expected_dates[$];
      int           fail_count = 0;

      function bit is_leap_year(int unsigned y);
         return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
      endfunction

      function int unsigned month_length(int unsigned m, int unsigned y);
         case (m)
            2: return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
         endcase
      endfunction

      function date_rec_type add_days(logic [cdad_pkg::DAY_W-1:0] d,
                                      logic [cdad_pkg::MONTH_W-1:0] m,
                                      logic [cdad_pkg::YEAR_W-1:0] y,
                                      logic [cdad_pkg::COUNT_W-1:0] n);
         date_rec_type r;
         int unsigned  dd, mm, yy, left, room;
         dd = d;
         mm = m;
         yy = y;
         left = n;
         r.day = d;
         r.month = m;
         r.year = y;
         if (m < cdad_pkg::MONTH_JAN || m > cdad_pkg::MONTH_DEC || d < cdad_pkg::DAY_FIRST ||
             d > month_length(m, y)) begin
            r.status = cdad_pkg::STATUS_INVALID;
            return r;
         end
         while (left > 0) begin
            room = month_length(mm, yy) - dd;
            if (left <= room) begin
               dd += left;
               left = 0;
            end else begin
               left -= room + 1;
               dd = 1;
               if (mm == cdad_pkg::MONTH_DEC) begin
                  mm = cdad_pkg::MONTH_JAN;
                  yy++;
               end else begin
                  mm++;
               end
            end
         end
         if (yy > YEAR_TOP) begin
            r.day = cdad_pkg::DAY_LAST;
            r.month = cdad_pkg::MONTH_DEC;
            r.year = 16'(YEAR_TOP);
            r.status = cdad_pkg::STATUS_OVERFLOW;
         end else begin
            r.day = 5'(dd);
            r.month = 4'(mm);
            r.year = 16'(yy);
            r.status = cdad_pkg::STATUS_OK;
         end
         return r;
      endfunction

      function void note_request(logic [cdad_pkg::DAY_W-1:0] d,
                                 logic [cdad_pkg::MONTH_W-1:0] m,
                                 logic [cdad_pkg::YEAR_W-1:0] y,
                                 logic [cdad_pkg::COUNT_W-1:0] n);
         expected_dates.push_back(add_days(d, m, y, n));
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction

      task report_mismatch(string msg);
         if (fail_count < 100)
            $display("mismatch: %s", msg);
         fail_count++;
      endtask

      task check_response(logic [cdad_pkg::DAY_W-1:0] d,
                          logic [cdad_pkg::MONTH_W-1:0] m,
                          logic [cdad_pkg::YEAR_W-1:0] y,
                          logic [cdad_pkg::STATUS_W-1:0] st);
         date_rec_type want;
         if (expected_dates.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction %0d/%0d/%0d status %0d",
                                      d, m, y, st));
            return;
         end
         want = expected_dates.pop_front();
         if (d !== want.day)
            report_mismatch($sformatf("day got %0d expected %0d", d, want.day));
         if (m !== want.month)
            report_mismatch($sformatf("month got %0d expected %0d", m, want.month));
         if (y !== want.year)
            report_mismatch($sformatf("year got %0d expected %0d", y, want.year));
         if (st !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", st, want.status));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [cdad_pkg::DAY_W-1:0]    req_in_day;
   logic [cdad_pkg::MONTH_W-1:0]  req_in_month;
   logic [cdad_pkg::YEAR_W-1:0]   req_in_year;
   logic [cdad_pkg::COUNT_W-1:0]  req_days_to_add;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [cdad_pkg::DAY_W-1:0]    rsp_out_day;
   logic [cdad_pkg::MONTH_W-1:0]  rsp_out_month;
   logic [cdad_pkg::YEAR_W-1:0]   rsp_out_year;
   logic [cdad_pkg::STATUS_W-1:0] rsp_status;

   bit calm = 1'b0;
   bit hold_request = 1'b0;

   date_scoreboard sb = new;

   calendar_date_add_days i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_day      (req_in_day),
      .req_in_month    (req_in_month),
      .req_in_year     (req_in_year),
      .req_days_to_add (req_days_to_add),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task drive_request(input logic [cdad_pkg::DAY_W-1:0] d,
                      input logic [cdad_pkg::MONTH_W-1:0] m,
                      input logic [cdad_pkg::YEAR_W-1:0] y,
                      input logic [cdad_pkg::COUNT_W-1:0] n);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_day <= d;
      req_in_month <= m;
      req_in_year <= y;
      req_days_to_add <= n;
      do @(posedge clock); while (!req_ready);
      sb.note_request(d, m, y, n);
   endtask

   task drive_random_request();
      int unsigned d, m, y, n, len;
      if ($urandom_range(99) < 12) begin
         d = $urandom_range(31);
         m = $urandom_range(15);
         y = $urandom_range(65535);
         n = $urandom_range(65535);
      end else begin
         m = $urandom_range(12, 1);
         case ($urandom_range(3))
            0: y = $urandom_range(65535);
            1: y = $urandom_range(65535, 65000);
            2: y = $urandom_range(2500, 1500);
            default: y = $urandom_range(655) * 100 + $urandom_range(4);
         endcase
         len = sb.month_length(m, y);
         d = ($urandom_range(4) == 0) ? len - $urandom_range(2) : $urandom_range(len, 1);
         case ($urandom_range(2))
            0: n = $urandom_range(40);
            1: n = $urandom_range(400);
            default: n = $urandom_range(65535);
         endcase
      end
      drive_request(5'(d), 4'(m), 16'(y), 16'(n));
   endtask

   // response side: check, then pick ready for the next edge
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_out_day, rsp_out_month, rsp_out_year, rsp_status);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < 21) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_day <= '0;
      req_in_month <= '0;
      req_in_year <= '0;
      req_days_to_add <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      drive_request(5'd1, 4'd1, 16'd2000, 16'd0);
      drive_request(5'd31, 4'd12, 16'd1999, 16'd1);
      drive_request(5'd28, 4'd2, 16'd1900, 16'd1);
      drive_request(5'd29, 4'd2, 16'd1900, 16'd0);
      drive_request(5'd29, 4'd2, 16'd2000, 16'd1);
      drive_request(5'd28, 4'd2, 16'd2004, 16'd1);
      drive_request(5'd29, 4'd2, 16'd0, 16'd365);
      drive_request(5'd0, 4'd5, 16'd2020, 16'd10);
      drive_request(5'd31, 4'd4, 16'd2021, 16'd3);
      drive_request(5'd1, 4'd0, 16'd2021, 16'd3);
      drive_request(5'd15, 4'd13, 16'd2021, 16'd3);
      drive_request(5'd31, 4'd15, 16'd65535, 16'd65535);
      drive_request(5'd1, 4'd1, 16'd0, 16'd65535);
      drive_request(5'd31, 4'd12, 16'd65535, 16'd0);
      drive_request(5'd31, 4'd12, 16'd65535, 16'd1);
      drive_request(5'd1, 4'd1, 16'd65535, 16'd364);
      drive_request(5'd1, 4'd1, 16'd65535, 16'd365);
      drive_request(5'd1, 4'd1, 16'd65400, 16'd65535);
      drive_request(5'd17, 4'd7, 16'd2024, 16'd65535);
      drive_request(5'd1, 4'd3, 16'd2100, 16'd146);
      drive_request(5'd30, 4'd11, 16'd1600, 16'd31);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 150 && i < 200);
         if (i == 60)
            hold_request = 1'b1;
         drive_random_request();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
